>>> src/dual_motor_setpoint_slew_limiter_unit_macros.svh
// Assertion macros shared by the slew limiter checker.
// No dependencies; include by bare file name.
`ifndef DUAL_MOTOR_SETPOINT_SLEW_LIMITER_UNIT_MACROS_SVH
`define DUAL_MOTOR_SETPOINT_SLEW_LIMITER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DMSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slew limiter check failed");

// Next-cycle implication, disabled during reset.
`define DMSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slew limiter check failed");

`endif

>>> src/dmsl_pkg.sv
// Shared widths, limits, register indexes and lane control type
// for the dual motor setpoint slew limiter. No dependencies.
`default_nettype none

package dmsl_pkg;

    localparam int REQ_W  = 16;
    localparam int CMD_W  = 9;
    localparam int MIN_W  = 8;
    localparam int STEP_W = 9;
    localparam int CFG_AW = 2;

    localparam int VEL_MAX = 255;

    localparam logic signed [REQ_W-1:0] REQ_HI = REQ_W'(VEL_MAX);
    localparam logic signed [REQ_W-1:0] REQ_LO = REQ_W'(-VEL_MAX);
    localparam logic signed [CMD_W-1:0] CMD_HI = CMD_W'(VEL_MAX);
    localparam logic signed [CMD_W-1:0] CMD_LO = CMD_W'(-VEL_MAX);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2 * VEL_MAX);

    typedef enum logic [CFG_AW-1:0] {
        CFG_MIN_SPEED = 2'd0,
        CFG_MAX_STEP  = 2'd1,
        CFG_REVERSED  = 2'd2,
        CFG_PAUSED    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              load;
        logic [STEP_W-1:0] max_step;
    } lane_ctrl_t;

endpackage

`default_nettype wire

>>> src/dmsl_shape.sv
// Request shaping for one wheel: saturate to +-255, raise small magnitudes
// to min_speed keeping the sign (zero counts as positive). Uses dmsl_pkg.
`default_nettype none

module dmsl_shape (
    input  wire logic signed [dmsl_pkg::REQ_W-1:0] req,
    input  wire logic        [dmsl_pkg::MIN_W-1:0] min_speed,
    output logic signed      [dmsl_pkg::CMD_W-1:0] shaped
);

    logic signed [dmsl_pkg::CMD_W-1:0] sat;
    logic        [dmsl_pkg::CMD_W-1:0] mag;
    logic signed [dmsl_pkg::CMD_W-1:0] min_s;

    always_comb
    begin
        if (req > dmsl_pkg::REQ_HI)
        begin
            sat = dmsl_pkg::CMD_HI;
        end
        else if (req < dmsl_pkg::REQ_LO)
        begin
            sat = dmsl_pkg::CMD_LO;
        end
        else
        begin
            sat = req[dmsl_pkg::CMD_W-1:0];
        end

        mag   = sat[dmsl_pkg::CMD_W-1] ? dmsl_pkg::CMD_W'(-sat) : sat;
        min_s = $signed({1'b0, min_speed});

        if (mag < {1'b0, min_speed})
        begin
            shaped = sat[dmsl_pkg::CMD_W-1] ? dmsl_pkg::CMD_W'(-min_s) : min_s;
        end
        else
        begin
            shaped = sat;
        end
    end

endmodule

`default_nettype wire

>>> src/dmsl_lane.sv
// One motor lane: slew-limits the target against the last command and
// holds that command. Uses dmsl_pkg.
`default_nettype none

module dmsl_lane (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dmsl_pkg::lane_ctrl_t              ctrl,
    input  wire logic signed [dmsl_pkg::CMD_W-1:0] target,
    output logic signed      [dmsl_pkg::CMD_W-1:0] cmd
);

    logic signed [dmsl_pkg::CMD_W-1:0] last_reg;
    logic signed [dmsl_pkg::CMD_W-1:0] last_next;
    logic signed [dmsl_pkg::CMD_W:0]   diff;
    logic        [dmsl_pkg::CMD_W-1:0] span;
    logic signed [dmsl_pkg::CMD_W+1:0] step_s;
    logic signed [dmsl_pkg::CMD_W+1:0] last_w;
    logic signed [dmsl_pkg::CMD_W+1:0] moved;

    always_comb
    begin
        diff   = {target[dmsl_pkg::CMD_W-1], target} - {last_reg[dmsl_pkg::CMD_W-1], last_reg};
        span   = diff[dmsl_pkg::CMD_W] ? dmsl_pkg::CMD_W'(-diff) : diff[dmsl_pkg::CMD_W-1:0];
        step_s = $signed({2'b00, ctrl.max_step});
        last_w = {{2{last_reg[dmsl_pkg::CMD_W-1]}}, last_reg};
        // move toward target by max_step; stays between last and target
        moved  = diff[dmsl_pkg::CMD_W] ? (last_w - step_s) : (last_w + step_s);

        if (span > ctrl.max_step)
        begin
            last_next = moved[dmsl_pkg::CMD_W-1:0];
        end
        else
        begin
            last_next = target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (ctrl.load)
        begin
            last_reg <= last_next;
        end
    end

    assign cmd = last_reg;

endmodule

`default_nettype wire

>>> src/dual_motor_setpoint_slew_limiter_unit.sv
// Pipeline: an input transfer is registered in the shape stage (s1), then in the
// slew stage command registers that drive m_tdata; a stalled output holds both.
// Throughput: one item per cycle unless the output stalls; the slew stage feeds back
// its own command register, so the per-lane loop is one subtract, compare and add.
// Reset (rst_n, async low): pipeline empty, last commands 0, min_speed 0,
// max_step 510, reversed 0, paused 0. Paused items are taken and dropped.
`default_nettype none

module dual_motor_setpoint_slew_limiter_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dmsl_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [dmsl_pkg::STEP_W-1:0]   cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,  // left_request[15:0], right_request[31:16]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata   // left_command[8:0], right_command[17:9], zero[23:18]
);

    logic [dmsl_pkg::MIN_W-1:0]  min_speed_reg;
    logic [dmsl_pkg::STEP_W-1:0] max_step_reg;
    logic                        reversed_reg;
    logic                        paused_reg;

    logic                               s1_valid_reg;
    logic signed [dmsl_pkg::CMD_W-1:0]  s1_left_reg;
    logic signed [dmsl_pkg::CMD_W-1:0]  s1_right_reg;
    logic                               m_valid_reg;

    logic signed [dmsl_pkg::CMD_W-1:0]  left_shaped;
    logic signed [dmsl_pkg::CMD_W-1:0]  right_shaped;
    logic signed [dmsl_pkg::CMD_W-1:0]  left_target;
    logic signed [dmsl_pkg::CMD_W-1:0]  right_target;
    logic signed [dmsl_pkg::CMD_W-1:0]  left_cmd;
    logic signed [dmsl_pkg::CMD_W-1:0]  right_cmd;

    logic                 advance;
    logic                 in_xfer;
    dmsl_pkg::lane_ctrl_t lane_ctrl;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg <= '0;
            max_step_reg  <= dmsl_pkg::STEP_RESET;
            reversed_reg  <= 1'b0;
            paused_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dmsl_pkg::CFG_MIN_SPEED: min_speed_reg <= cfg_wdata[dmsl_pkg::MIN_W-1:0];
                dmsl_pkg::CFG_MAX_STEP:  max_step_reg  <= cfg_wdata;
                dmsl_pkg::CFG_REVERSED:  reversed_reg  <= cfg_wdata[0];
                dmsl_pkg::CFG_PAUSED:    paused_reg    <= cfg_wdata[0];
                default:                 ;
            endcase
        end
    end

    // shaping stage
    dmsl_shape u_shape_left (
        .req       (s_tdata[15:0]),
        .min_speed (min_speed_reg),
        .shaped    (left_shaped)
    );

    dmsl_shape u_shape_right (
        .req       (s_tdata[31:16]),
        .min_speed (min_speed_reg),
        .shaped    (right_shaped)
    );

    always_comb
    begin
        if (reversed_reg)
        begin
            left_target  = dmsl_pkg::CMD_W'(-right_shaped);
            right_target = dmsl_pkg::CMD_W'(-left_shaped);
        end
        else
        begin
            left_target  = left_shaped;
            right_target = right_shaped;
        end
    end

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance || !s1_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid && !paused_reg;
            end
            if (advance)
            begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_left_reg  <= left_target;
            s1_right_reg <= right_target;
        end
    end

    // slew stage: lanes own the command registers
    assign lane_ctrl = {s1_valid_reg && advance, max_step_reg};

    dmsl_lane u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .target (s1_left_reg),
        .cmd    (left_cmd)
    );

    dmsl_lane u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .target (s1_right_reg),
        .cmd    (right_cmd)
    );

    // merge lanes onto the output bus
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, right_cmd, left_cmd};

endmodule

`default_nettype wire

>>> src/dmsl_checker.sv
// Port-level checks for the slew limiter, bound to the top level.
// Depends on dual_motor_setpoint_slew_limiter_unit_macros.svh.
`default_nettype none
`include "dual_motor_setpoint_slew_limiter_unit_macros.svh"

module dmsl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // a held result keeps its data
    `DMSL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // input only stalls when both stages are full and the sink is stalled
    `DMSL_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)

    // commands never reach -256
    `DMSL_ASSERT_NOW(a_cmd_range, clk, rst_n, m_tvalid, (m_tdata[8:0] != 9'h100) && (m_tdata[17:9] != 9'h100))

    // padding stays clear
    `DMSL_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[23:18] == 6'b000000)

endmodule

bind dual_motor_setpoint_slew_limiter_unit dmsl_checker u_dmsl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
